// ===== sv/sgi_pkg.sv =====
package sgi_pkg;

  localparam int SGI_COORD_W = 16;

  typedef struct packed {
    logic hit;
    logic par;
    logic col;
  } sgi_flags_t;

endpackage

// ===== sv/sgi_front.sv =====
module sgi_front #(
  parameter int COORD_WIDTH = sgi_pkg::SGI_COORD_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] d_x,
  input  logic signed [COORD_WIDTH-1:0] d_y,
  output logic                          o_vld,
  output sgi_pkg::sgi_flags_t           o_flags,
  output logic [2*COORD_WIDTH+2:0]      o_den,
  output logic [2*COORD_WIDTH+2:0]      o_rn,
  output logic [2*COORD_WIDTH+1:0]      o_sumsq,
  output logic signed [COORD_WIDTH-1:0] o_ax,
  output logic signed [COORD_WIDTH-1:0] o_ay,
  output logic signed [COORD_WIDTH:0]   o_ex,
  output logic signed [COORD_WIDTH:0]   o_ey
);
  import sgi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2*W + 2;
  localparam int DW = 2*W + 3;

  // stage 1: differences
  logic                v1_r;
  logic signed [W-1:0] ax1_r, ay1_r;
  logic signed [W:0]   ex1_r, ey1_r, fx1_r, fy1_r, gx1_r, gy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    ax1_r <= a_x;
    ay1_r <= a_y;
    ex1_r <= (W+1)'(b_x) - (W+1)'(a_x);
    ey1_r <= (W+1)'(b_y) - (W+1)'(a_y);
    fx1_r <= (W+1)'(d_x) - (W+1)'(c_x);
    fy1_r <= (W+1)'(d_y) - (W+1)'(c_y);
    gx1_r <= (W+1)'(a_x) - (W+1)'(c_x);
    gy1_r <= (W+1)'(a_y) - (W+1)'(c_y);
  end

  // stage 2: products
  logic                 v2_r;
  logic signed [W-1:0]  ax2_r, ay2_r;
  logic signed [W:0]    ex2_r, ey2_r;
  logic signed [PW-1:0] p_exfy_r, p_eyfx_r, p_gyfx_r, p_gxfy_r, p_gyex_r, p_gxey_r;
  logic signed [PW-1:0] p_exex_r, p_eyey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ax2_r    <= ax1_r;
    ay2_r    <= ay1_r;
    ex2_r    <= ex1_r;
    ey2_r    <= ey1_r;
    p_exfy_r <= ex1_r * fy1_r;
    p_eyfx_r <= ey1_r * fx1_r;
    p_gyfx_r <= gy1_r * fx1_r;
    p_gxfy_r <= gx1_r * fy1_r;
    p_gyex_r <= gy1_r * ex1_r;
    p_gxey_r <= gx1_r * ey1_r;
    p_exex_r <= ex1_r * ex1_r;
    p_eyey_r <= ey1_r * ey1_r;
  end

  // stage 3: cross products and squared length
  logic                 v3_r;
  logic signed [W-1:0]  ax3_r, ay3_r;
  logic signed [W:0]    ex3_r, ey3_r;
  logic signed [DW-1:0] den3_r, rn3_r, sn3_r;
  logic [PW-1:0]        sumsq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ax3_r    <= ax2_r;
    ay3_r    <= ay2_r;
    ex3_r    <= ex2_r;
    ey3_r    <= ey2_r;
    den3_r   <= DW'(p_exfy_r) - DW'(p_eyfx_r);
    rn3_r    <= DW'(p_gyfx_r) - DW'(p_gxfy_r);
    sn3_r    <= DW'(p_gyex_r) - DW'(p_gxey_r);
    sumsq3_r <= PW'(p_exex_r) + PW'(p_eyey_r);
  end

  // stage 4: sign normalize, classify
  logic signed [DW-1:0] d_nxt, r_nxt, s_nxt;
  sgi_flags_t           flags_nxt;

  always_comb begin
    if (den3_r < 0) begin
      d_nxt = -den3_r;
      r_nxt = -rn3_r;
      s_nxt = -sn3_r;
    end else begin
      d_nxt = den3_r;
      r_nxt = rn3_r;
      s_nxt = sn3_r;
    end
    flags_nxt.par = (den3_r == '0);
    flags_nxt.col = flags_nxt.par && (rn3_r == '0) && (sn3_r == '0);
    flags_nxt.hit = !flags_nxt.par && (d_nxt > 0) && (r_nxt > 0) && (r_nxt < d_nxt) &&
                    (s_nxt > 0) && (s_nxt < d_nxt);
  end

  logic       v4_r;
  sgi_flags_t flags4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    flags4_r <= flags_nxt;
    o_den    <= d_nxt;
    o_rn     <= r_nxt;
    o_sumsq  <= sumsq3_r;
    o_ax     <= ax3_r;
    o_ay     <= ay3_r;
    o_ex     <= ex3_r;
    o_ey     <= ey3_r;
  end

  assign o_vld   = v4_r;
  assign o_flags = flags4_r;

endmodule

// ===== sv/sgi_isqrt.sv =====
module sgi_isqrt #(
  parameter int RW = 17
) (
  input  logic            clk,
  input  logic [2*RW-1:0] s_in,
  output logic [RW-1:0]   root
);

  localparam int SW = 2*RW;

  logic [RW+1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] src_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic [RW+1:0] rem_i;
    logic [RW-1:0] root_i;
    logic [SW-1:0] src_i;
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic          take;
    logic [RW+1:0] rem_nxt;
    logic [RW-1:0] root_nxt;
    logic [SW-1:0] src_nxt;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign src_i  = s_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign src_i  = src_r[k-1];
    end

    assign t        = {rem_i, src_i[SW-1 -: 2]};
    assign trial    = {2'b00, root_i, 2'b01};
    assign take     = (t >= trial);
    assign rem_nxt  = take ? (RW+2)'(t - trial) : (RW+2)'(t);
    assign root_nxt = {root_i[RW-2:0], take};
    assign src_nxt  = {src_i[SW-3:0], 2'b00};

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      src_r[k]  <= src_nxt;
    end
  end

  assign root = root_r[RW-1];

endmodule

// ===== sv/sgi_div.sv =====
module sgi_div #(
  parameter int NW = 53,
  parameter int DW = 35,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] d_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic [DW-1:0] rem_i;
    logic [QW-1:0] lo_i;
    logic [QW-1:0] q_i;
    logic [DW-1:0] d_i;
    logic [DW:0]   t;
    logic          take;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_i = num[QW+DW-1:QW];
      assign lo_i  = num[QW-1:0];
      assign q_i   = '0;
      assign d_i   = den;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign lo_i  = lo_r[k-1];
      assign q_i   = q_r[k-1];
      assign d_i   = d_r[k-1];
    end

    assign t       = {rem_i, lo_i[QW-1]};
    assign take    = (t >= {1'b0, d_i});
    assign rem_nxt = take ? DW'(t - {1'b0, d_i}) : DW'(t);

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      lo_r[k]  <= {lo_i[QW-2:0], 1'b0};
      q_r[k]   <= {q_i[QW-2:0], take};
      d_r[k]   <= d_i;
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ===== sv/segment_intersection_2d.sv =====
// Throughput: one transaction per cycle; busy is always low.
// Depth is set by the bit-per-stage square root (COORD_WIDTH+1 stages) and the
// bit-per-stage dividers (COORD_WIDTH+1 stages).
// Synchronous active-low reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall: each result shows for exactly one cycle.
module segment_intersection_2d #(
  parameter int COORD_WIDTH = sgi_pkg::SGI_COORD_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_d_x,
  input  logic signed [COORD_WIDTH-1:0] in_d_y,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic                          out_parallel,
  output logic                          out_collinear,
  output logic [COORD_WIDTH:0]          out_distance_along,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y
);
  import sgi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int RW = W + 1;
  localparam int DW = 2*W + 3;
  localparam int NW = 3*W + 5;
  localparam int QW = W + 1;
  localparam int PLW = DW + DW + 3 + W + W + (W+1) + (W+1);

  assign busy = 1'b0;

  logic                 f_vld;
  sgi_flags_t           f_flags;
  logic [DW-1:0]        f_den, f_rn;
  logic [2*W+1:0]       f_sumsq;
  logic signed [W-1:0]  f_ax, f_ay;
  logic signed [W:0]    f_ex, f_ey;

  sgi_front #(.COORD_WIDTH(W)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .a_x     (in_a_x),
    .a_y     (in_a_y),
    .b_x     (in_b_x),
    .b_y     (in_b_y),
    .c_x     (in_c_x),
    .c_y     (in_c_y),
    .d_x     (in_d_x),
    .d_y     (in_d_y),
    .o_vld   (f_vld),
    .o_flags (f_flags),
    .o_den   (f_den),
    .o_rn    (f_rn),
    .o_sumsq (f_sumsq),
    .o_ax    (f_ax),
    .o_ay    (f_ay),
    .o_ex    (f_ex),
    .o_ey    (f_ey)
  );

  // square root with matching payload delay
  logic [RW-1:0] len;

  sgi_isqrt #(.RW(RW)) u_isqrt (
    .clk  (clk),
    .s_in (f_sumsq),
    .root (len)
  );

  logic [PLW-1:0] pl_r  [RW];
  logic [RW-1:0]  plv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plv_r <= '0;
    end else begin
      plv_r <= {plv_r[RW-2:0], f_vld};
    end
  end

  always_ff @(posedge clk) begin
    pl_r[0] <= {f_den, f_rn, f_flags, f_ax, f_ay, f_ex, f_ey};
    for (int i = 1; i < RW; i++) begin
      pl_r[i] <= pl_r[i-1];
    end
  end

  logic [DW-1:0]       q_den, q_rn;
  sgi_flags_t          q_flags;
  logic signed [W-1:0] q_ax, q_ay;
  logic signed [W:0]   q_ex, q_ey;

  assign {q_den, q_rn, q_flags, q_ax, q_ay, q_ex, q_ey} = pl_r[RW-1];

  // multiply stage
  logic                  m_vld_r;
  sgi_flags_t            m_flags_r;
  logic [DW-1:0]         m_den_r;
  logic [RW+DW-1:0]      m_dist_r;
  logic signed [W+DW:0]  m_axd_r, m_ayd_r;
  logic signed [NW-1:0]  m_rex_r, m_rey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= plv_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    m_flags_r <= q_flags;
    m_den_r   <= q_den;
    m_dist_r  <= len * q_rn;
    m_axd_r   <= q_ax * $signed({1'b0, q_den});
    m_ayd_r   <= q_ay * $signed({1'b0, q_den});
    m_rex_r   <= $signed({1'b0, q_rn}) * q_ex;
    m_rey_r   <= $signed({1'b0, q_rn}) * q_ey;
  end

  // numerator stage: sum, magnitude, sign
  logic signed [NW-1:0] nx_nxt, ny_nxt;

  assign nx_nxt = NW'(m_axd_r) + m_rex_r;
  assign ny_nxt = NW'(m_ayd_r) + m_rey_r;

  logic          n_vld_r;
  sgi_flags_t    n_flags_r;
  logic [DW-1:0] n_den_r;
  logic [NW-1:0] n_dist_r, n_x_r, n_y_r;
  logic          n_sx_r, n_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else begin
      n_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    n_flags_r <= m_flags_r;
    n_den_r   <= m_den_r;
    n_dist_r  <= NW'(m_dist_r);
    n_x_r     <= nx_nxt[NW-1] ? NW'(-nx_nxt) : NW'(nx_nxt);
    n_y_r     <= ny_nxt[NW-1] ? NW'(-ny_nxt) : NW'(ny_nxt);
    n_sx_r    <= nx_nxt[NW-1];
    n_sy_r    <= ny_nxt[NW-1];
  end

  // dividers
  logic [QW-1:0] qd, qx, qy;

  sgi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_dist (
    .clk (clk), .num (n_dist_r), .den (n_den_r), .quo (qd)
  );

  sgi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
    .clk (clk), .num (n_x_r), .den (n_den_r), .quo (qx)
  );

  sgi_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
    .clk (clk), .num (n_y_r), .den (n_den_r), .quo (qy)
  );

  logic [4:0]    dq_r [QW];
  logic [QW-1:0] dqv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dqv_r <= '0;
    end else begin
      dqv_r <= {dqv_r[QW-2:0], n_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    dq_r[0] <= {n_flags_r, n_sx_r, n_sy_r};
    for (int i = 1; i < QW; i++) begin
      dq_r[i] <= dq_r[i-1];
    end
  end

  sgi_flags_t    z_flags;
  logic          z_sx, z_sy;
  logic [QW-1:0] qx_s, qy_s;

  assign {z_flags, z_sx, z_sy} = dq_r[QW-1];
  assign qx_s = z_sx ? -qx : qx;
  assign qy_s = z_sy ? -qy : qy;

  // output register
  logic                out_valid_r;
  logic                hit_r, par_r, col_r;
  logic [W:0]          dist_r;
  logic signed [W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dqv_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= z_flags.hit;
    par_r  <= z_flags.par;
    col_r  <= z_flags.col;
    dist_r <= z_flags.hit ? qd : '0;
    px_r   <= z_flags.hit ? $signed(qx_s[W-1:0]) : '0;
    py_r   <= z_flags.hit ? $signed(qy_s[W-1:0]) : '0;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_parallel       = par_r;
  assign out_collinear      = col_r;
  assign out_distance_along = dist_r;
  assign out_point_x        = px_r;
  assign out_point_y        = py_r;

endmodule

// ===== sv/sgi_checker.sv =====
module sgi_checker #(
  parameter int COORD_WIDTH = sgi_pkg::SGI_COORD_W
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_hit,
  input logic                          out_parallel,
  input logic                          out_collinear,
  input logic [COORD_WIDTH:0]          out_distance_along,
  input logic signed [COORD_WIDTH-1:0] out_point_x,
  input logic signed [COORD_WIDTH-1:0] out_point_y
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_hit_not_par: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_parallel && !out_collinear)
    else $error("hit reported with parallel or collinear");

  a_col_par: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_collinear |-> out_parallel)
    else $error("collinear without parallel");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |->
      out_distance_along == '0 && out_point_x == '0 && out_point_y == '0)
    else $error("nonzero geometry on a miss");

endmodule

bind segment_intersection_2d sgi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sgi_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_hit            (out_hit),
  .out_parallel       (out_parallel),
  .out_collinear      (out_collinear),
  .out_distance_along (out_distance_along),
  .out_point_x        (out_point_x),
  .out_point_y        (out_point_y)
);
